FILE: design/buvs_pkg.sv
// Shared types and constants for the battery undervoltage supervisor.
`timescale 1ns / 1ps

package buvs_pkg;

    // Field widths
    localparam int unsigned SOC_W     = 7;
    localparam int unsigned CHARGE_W  = 8;
    localparam int unsigned MV_W      = 13;
    localparam int unsigned LIM_MV_W  = MV_W + 1;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned LED_W     = 2;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CELL_IDX_W = 3;
    localparam int unsigned CELL_MAX  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 13;

    // Input tdata layout
    localparam int unsigned IN_CELL_LSB = CHARGE_W;
    localparam int unsigned IN_HOUR_LSB = IN_CELL_LSB + CELL_MAX * MV_W;
    localparam int unsigned IN_BAT_BIT  = IN_HOUR_LSB + HOUR_W;
    localparam int unsigned IN_DATA_W   = 120;

    // Output tdata width
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHG_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHG_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HYST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_END   = 3'd7;

    // LED colors
    localparam logic [LED_W-1:0] LED_UNSET = 2'd0;
    localparam logic [LED_W-1:0] LED_OK    = 2'd1;
    localparam logic [LED_W-1:0] LED_RED   = 2'd2;

    // Fault kinds
    localparam logic [KIND_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [KIND_W-1:0] FAULT_SOC  = 2'd1;
    localparam logic [KIND_W-1:0] FAULT_CELL = 2'd2;

    // Merged cell verdict
    typedef struct packed {
        logic                  any_low;
        logic [CELL_IDX_W-1:0] idx;
    } t_cell_result;

endpackage

FILE: design/battery_undervoltage_supervisor.sv
// Top level: config registers, cell lanes, supervisor state and output register.
// A result is registered: it is valid in the cycle after its input transfer.
// Throughput: one item per cycle; input ready while the output register is
//   empty or being drained in the same cycle.
// The state update is a combinational compare and select on registered state.
// Reset: synchronous active-low; clears state, output valid and restores
//   register defaults.
`timescale 1ns / 1ps

module battery_undervoltage_supervisor #(
    parameter int unsigned CELL_COUNT = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [buvs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [buvs_pkg::CFG_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: charge_percent[7:0], cell_mv_0..7 (13 bits each) [111:8],
    //        hour_of_day[116:112], battery_running[117], zero pad[119:118]
    input  logic [buvs_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: cmd (0 check, 1 button)
    input  logic                             i_s_axis_tuser,
    // Output stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: relay_battery[0], stop_latched[1], failure_count[9:2],
    //        led_color[11:10], fault_kind[13:12], fault_cell[16:14],
    //        night_active[17], zero pad[23:18]
    output logic [buvs_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import buvs_pkg::*;

    // Configuration registers
    logic [SOC_W-1:0]  r_chg_floor;
    logic [SOC_W-1:0]  r_chg_margin;
    logic [MV_W-1:0]   r_cell_low;
    logic [MV_W-1:0]   r_cell_hyst;
    logic [CNT_W-1:0]  r_error_limit;
    logic              r_test_mode;
    logic [HOUR_W-1:0] r_night_start;
    logic [HOUR_W-1:0] r_night_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_floor   <= SOC_W'(30);
            r_chg_margin  <= SOC_W'(5);
            r_cell_low    <= MV_W'(3000);
            r_cell_hyst   <= MV_W'(50);
            r_error_limit <= CNT_W'(2);
            r_test_mode   <= 1'b0;
            r_night_start <= HOUR_W'(20);
            r_night_end   <= HOUR_W'(9);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHG_FLOOR:   r_chg_floor   <= i_cfg_data[SOC_W-1:0];
                REG_CHG_MARGIN:  r_chg_margin  <= i_cfg_data[SOC_W-1:0];
                REG_CELL_LOW:    r_cell_low    <= i_cfg_data[MV_W-1:0];
                REG_CELL_HYST:   r_cell_hyst   <= i_cfg_data[MV_W-1:0];
                REG_ERROR_LIMIT: r_error_limit <= i_cfg_data[CNT_W-1:0];
                REG_TEST_MODE:   r_test_mode   <= i_cfg_data[0];
                REG_NIGHT_START: r_night_start <= i_cfg_data[HOUR_W-1:0];
                REG_NIGHT_END:   r_night_end   <= i_cfg_data[HOUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic [CHARGE_W-1:0] charge;
    logic [HOUR_W-1:0]   hour;
    logic                bat_on;
    logic                cmd_button;

    assign charge     = i_s_axis_tdata[CHARGE_W-1:0];
    assign hour       = i_s_axis_tdata[IN_HOUR_LSB +: HOUR_W];
    assign bat_on     = i_s_axis_tdata[IN_BAT_BIT];
    assign cmd_button = i_s_axis_tuser;

    // Active limits, raised by the hysteresis while the battery is off
    logic [SOC_W:0]        soc_lim;
    logic [LIM_MV_W-1:0]   cell_lim;

    assign soc_lim  = {1'b0, r_chg_floor} + (bat_on ? '0 : {1'b0, r_chg_margin});
    assign cell_lim = {1'b0, r_cell_low} + (bat_on ? '0 : {1'b0, r_cell_hyst});

    // Cell lanes
    logic [CELL_COUNT-1:0] cell_low;

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_lane
        buvs_cell_lane u_lane (
            .i_cell_mv  (i_s_axis_tdata[IN_CELL_LSB + k * MV_W +: MV_W]),
            .i_limit_mv (cell_lim),
            .o_low      (cell_low[k])
        );
    end

    t_cell_result cell_res;

    buvs_fault_merge #(
        .LANES (CELL_COUNT)
    ) u_merge (
        .i_low    (cell_low),
        .o_result (cell_res)
    );

    // Supervisor state
    logic              r_relay, n_relay;
    logic              r_stop, n_stop;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_night, n_night;
    logic [LED_W-1:0]  r_led, n_led;
    logic [KIND_W-1:0]     kind;
    logic [CELL_IDX_W-1:0] fcell;

    logic              soc_fail;
    logic              check_fail;
    logic [CNT_W-1:0]  count_inc;
    logic              in_window;

    assign soc_fail   = (charge < {1'b0, soc_lim});
    assign check_fail = soc_fail || cell_res.any_low;
    assign count_inc  = (r_count != CNT_MAX) ? r_count + 1'b1 : r_count;
    assign in_window  = (hour >= r_night_start) || (hour < r_night_end);

    // Next state for one item
    always_comb begin
        n_relay = r_relay;
        n_stop  = r_stop;
        n_count = r_count;
        n_night = r_night;
        n_led   = r_led;
        kind    = FAULT_NONE;
        fcell   = '0;
        if (cmd_button) begin
            // Toggle, never into battery mode while stopped
            n_relay = !r_relay && !r_stop;
        end else if (!charge[CHARGE_W-1] && !r_test_mode) begin
            if (check_fail) begin
                if (soc_fail) begin
                    kind = FAULT_SOC;
                end else begin
                    kind  = FAULT_CELL;
                    fcell = cell_res.idx;
                end
                n_count = count_inc;
                if (count_inc >= r_error_limit) begin
                    n_stop  = 1'b1;
                    n_relay = 1'b0;
                    n_led   = LED_RED;
                end
            end else begin
                if (r_count >= r_error_limit) begin
                    n_count = '0;
                end
                n_stop = 1'b0;
                n_led  = LED_OK;
                // Night window entry and exit
                if (in_window) begin
                    if (!r_night) begin
                        if (!bat_on) begin
                            n_relay = 1'b1;
                        end
                        n_night = 1'b1;
                    end
                end else if (r_night) begin
                    n_night = 1'b0;
                    if (bat_on) begin
                        n_relay = 1'b0;
                    end
                end
            end
        end
    end

    // Handshake: output register frees the input side
    logic r_out_valid;
    logic in_xfer;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay     <= 1'b0;
            r_stop      <= 1'b0;
            r_count     <= '0;
            r_night     <= 1'b0;
            r_led       <= LED_UNSET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_relay <= n_relay;
                r_stop  <= n_stop;
                r_count <= n_count;
                r_night <= n_night;
                r_led   <= n_led;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= {6'b0, n_night, fcell, kind, n_led, n_count, n_stop, n_relay};
        end
    end

    assign o_m_axis_tdata = r_out_data;

    // Checks on the supervisor state
    a_stop_red : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop == (r_led == LED_RED))
        else $error("stop flag and red LED disagree");

    a_stop_grid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> !r_relay)
        else $error("relay in battery mode while stop latched");

    a_cell_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[13:12] != FAULT_CELL) |-> (r_out_data[16:14] == '0))
        else $error("fault cell set without a cell fault");

endmodule

FILE: design/buvs_cell_lane.sv
// One cell lane: compares a cell voltage with the active limit.
`timescale 1ns / 1ps

module buvs_cell_lane (
    input  logic [buvs_pkg::MV_W-1:0]     i_cell_mv,
    input  logic [buvs_pkg::LIM_MV_W-1:0] i_limit_mv,
    output logic                          o_low
);
    import buvs_pkg::*;

    // Cell under the limit
    assign o_low = ({1'b0, i_cell_mv} < i_limit_mv);

endmodule

FILE: design/buvs_fault_merge.sv
// Merges lane verdicts into an any-low flag and the lowest failing cell index.
`timescale 1ns / 1ps

module buvs_fault_merge #(
    parameter int unsigned LANES = 8
) (
    input  logic [LANES-1:0]       i_low,
    output buvs_pkg::t_cell_result o_result
);
    import buvs_pkg::*;

    // Priority pick, lowest index wins
    always_comb begin
        o_result.any_low = |i_low;
        o_result.idx     = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (i_low[k]) begin
                o_result.idx = CELL_IDX_W'(k);
            end
        end
    end

endmodule
